>>> design/gpst_pkg.sv
// shared types, constants and helpers for the gradient peak and saccade tracker
package gpst_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int COUNT_BITS     = 8;
    localparam int CFG_COUNT_BITS = 8;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CMP_BITS       = (COUNT_BITS > CFG_COUNT_BITS) ? COUNT_BITS : CFG_COUNT_BITS;

    typedef logic [SAMPLE_BITS-1:0]    t_sample;
    typedef logic [COUNT_BITS-1:0]     t_count;
    typedef logic [CFG_COUNT_BITS-1:0] t_cfg_count;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_NEW_RUN = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_FALLS_BEFORE_SACCADE = 2'd0,
        CFG_RISES_BEFORE_FOUND   = 2'd1,
        CFG_FALLS_AFTER_PEAK     = 2'd2,
        CFG_PEAK_THRESHOLD       = 2'd3
    } t_cfg_idx;

    localparam t_cfg_count RST_FALLS_BEFORE_SACCADE = t_cfg_count'(5);
    localparam t_cfg_count RST_RISES_BEFORE_FOUND   = t_cfg_count'(3);
    localparam t_cfg_count RST_FALLS_AFTER_PEAK     = t_cfg_count'(1);
    localparam t_sample    RST_PEAK_THRESHOLD       = t_sample'(800);

    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        t_kind   kind;
        t_sample temperature;
        t_sample concentration;
        t_sample conc_right;
        t_sample conc_left;
    } t_in_beat;

    typedef struct packed {
        logic target_found;
        logic saccade;
        logic turn_right;
    } t_out_beat;

    typedef struct packed {
        t_cfg_count falls_before_saccade;
        t_cfg_count rises_before_found;
        t_cfg_count falls_after_peak;
        t_sample    peak_threshold;
    } t_cfg;

    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? COUNT_MAX : t_count'(v + t_count'(1));
    endfunction

    // counter reaches configured limit
    function automatic logic cnt_ge(input t_count cnt, input t_cfg_count lim);
        return CMP_BITS'(cnt) >= CMP_BITS'(lim);
    endfunction

endpackage

>>> design/gpst_cfg.sv
// configuration register file of the tracker
module gpst_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [gpst_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output gpst_pkg::t_cfg                 o_cfg
);
    import gpst_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.falls_before_saccade <= RST_FALLS_BEFORE_SACCADE;
            r_cfg.rises_before_found   <= RST_RISES_BEFORE_FOUND;
            r_cfg.falls_after_peak     <= RST_FALLS_AFTER_PEAK;
            r_cfg.peak_threshold       <= RST_PEAK_THRESHOLD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FALLS_BEFORE_SACCADE: begin
                    r_cfg.falls_before_saccade <= i_cfg_data[CFG_COUNT_BITS-1:0];
                end
                CFG_RISES_BEFORE_FOUND: begin
                    r_cfg.rises_before_found <= i_cfg_data[CFG_COUNT_BITS-1:0];
                end
                CFG_FALLS_AFTER_PEAK: begin
                    r_cfg.falls_after_peak <= i_cfg_data[CFG_COUNT_BITS-1:0];
                end
                CFG_PEAK_THRESHOLD: begin
                    r_cfg.peak_threshold <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/gpst_core.sv
// tracking state and its update for one beat (sample, clear or new run)
module gpst_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  gpst_pkg::t_in_beat  i_item,
    input  gpst_pkg::t_cfg      i_cfg,
    output gpst_pkg::t_out_beat o_res
);
    import gpst_pkg::*;

    t_sample r_prev_t, n_prev_t;
    logic    r_ptv, n_ptv;
    t_count  r_rise, n_rise;
    t_count  r_fall, n_fall;
    t_sample r_peak, n_peak;
    t_sample r_prev_c, n_prev_c;
    logic    r_pcv, n_pcv;
    t_count  r_drop, n_drop;
    logic    r_found, n_found;
    logic    sac, right;
    t_count  fall_inc, drop_inc;
    t_sample peak_sel;

    always_comb begin
        n_prev_t = r_prev_t;
        n_ptv    = r_ptv;
        n_rise   = r_rise;
        n_fall   = r_fall;
        n_peak   = r_peak;
        n_prev_c = r_prev_c;
        n_pcv    = r_pcv;
        n_drop   = r_drop;
        n_found  = r_found;
        sac      = 1'b0;
        right    = 1'b0;
        fall_inc = sat_inc(r_fall);
        drop_inc = sat_inc(r_drop);
        peak_sel = (fall_inc == t_count'(1)) ? r_prev_t : r_peak;

        case (i_item.kind)
            KIND_CLEAR: begin
                n_ptv  = 1'b0;
                n_rise = '0;
                n_fall = '0;
                n_pcv  = 1'b0;
                n_drop = '0;
            end
            KIND_NEW_RUN: begin
                n_ptv    = 1'b0;
                n_rise   = '0;
                n_fall   = '0;
                n_pcv    = 1'b0;
                n_drop   = '0;
                n_prev_t = '0;
                n_prev_c = '0;
                n_peak   = '0;
                n_found  = 1'b0;
            end
            KIND_SAMPLE: begin
                if (!r_found) begin
                    // temperature run tracking
                    if (r_ptv && (i_item.temperature > r_prev_t)) begin
                        if (r_fall != '0) begin
                            n_fall = '0;
                            n_rise = t_count'(1);
                        end else begin
                            n_rise = sat_inc(r_rise);
                        end
                    end else if (r_ptv && (i_item.temperature < r_prev_t)) begin
                        n_fall = fall_inc;
                        n_peak = peak_sel;
                        if (cnt_ge(fall_inc, i_cfg.falls_after_peak) &&
                            cnt_ge(r_rise, i_cfg.rises_before_found)) begin
                            if (peak_sel > i_cfg.peak_threshold) begin
                                n_found = 1'b1;
                            end else begin
                                n_fall = '0;
                            end
                        end
                    end
                    n_prev_t = i_item.temperature;
                    n_ptv    = 1'b1;

                    // concentration drop tracking
                    if (!n_found) begin
                        if (r_pcv && (i_item.concentration < r_prev_c)) begin
                            n_drop = drop_inc;
                            if (cnt_ge(drop_inc, i_cfg.falls_before_saccade)) begin
                                sac    = 1'b1;
                                right  = (i_item.conc_right >= i_item.conc_left);
                                n_ptv  = 1'b0;
                                n_rise = '0;
                                n_fall = '0;
                                n_pcv  = 1'b0;
                                n_drop = '0;
                            end else begin
                                n_prev_c = i_item.concentration;
                            end
                        end else begin
                            n_prev_c = i_item.concentration;
                            n_pcv    = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_t <= '0;
            r_ptv    <= 1'b0;
            r_rise   <= '0;
            r_fall   <= '0;
            r_peak   <= '0;
            r_prev_c <= '0;
            r_pcv    <= 1'b0;
            r_drop   <= '0;
            r_found  <= 1'b0;
        end else if (i_en) begin
            r_prev_t <= n_prev_t;
            r_ptv    <= n_ptv;
            r_rise   <= n_rise;
            r_fall   <= n_fall;
            r_peak   <= n_peak;
            r_prev_c <= n_prev_c;
            r_pcv    <= n_pcv;
            r_drop   <= n_drop;
            r_found  <= n_found;
        end
    end

    assign o_res.target_found = n_found;
    assign o_res.saccade      = sac;
    assign o_res.turn_right   = right;

`ifndef ASSERT_OFF
    a_turn_needs_saccade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.turn_right |-> o_res.saccade)
        else $error("turn_right without saccade");

    a_saccade_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.saccade |-> !o_res.target_found)
        else $error("saccade while target found");

    a_new_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (i_item.kind == KIND_NEW_RUN)) |=>
            (!r_found && (r_rise == '0) && (r_drop == '0) && !r_ptv))
        else $error("new run left tracking state");

    a_saccade_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.saccade) |=> ((r_drop == '0) && !r_pcv && (r_fall == '0)))
        else $error("saccade left tracking state");
`endif

endmodule

>>> design/gradient_peak_and_saccade_tracker_top.sv
// top level of the gradient peak and saccade tracker: beat registers and handshake
// One beat is accepted per clock while the output does not stall, and its result beat
// passes two registers: the beat is first captured in the input register, then the
// tracking state is updated while the result is written to the output register.
// Throughput is one beat per cycle when the output does not stall;
// a stall on the output backs up through both registers to the input.
// Configuration writes take effect on the next clock.
module gradient_peak_and_saccade_tracker_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  gpst_pkg::t_in_beat                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output gpst_pkg::t_out_beat                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [gpst_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import gpst_pkg::*;

    t_in_beat  r_in;
    logic      r_in_vld;
    t_out_beat r_out;
    logic      r_out_vld;
    t_out_beat res;
    t_cfg      cfg;
    logic      adv;
    logic      in_take;

    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    gpst_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gpst_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_adv_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> r_in_vld)
        else $error("core advanced without a beat");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("result beat lost");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_vld)
        else $error("held input beat dropped");
`endif

endmodule
